// ----- rtl/ars_pkg.sv -----
`default_nettype none

package ars_pkg;

	// Field widths fixed by the slot and result formats
	localparam int SAT_W      = 5;
	localparam int CHAN_W     = 4;
	localparam int WIN_W      = 15;
	localparam int PER_W      = 6;
	localparam int OPC_W      = 2;
	localparam int MODE_W     = 2;
	localparam int DOP_W      = 32;
	localparam int CENTRE_W   = 16;
	localparam int BOUND_W    = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// Request types
	localparam logic REQ_UPDATE = 1'b0;
	localparam logic REQ_SLOT   = 1'b1;

	// Operation codes for strong and weak acquisitions
	localparam logic [OPC_W-1:0] OP_OFF      = 2'd0;
	localparam logic [OPC_W-1:0] OP_NOT_COLD = 2'd1;
	localparam logic [OPC_W-1:0] OP_ALWAYS   = 2'd2;

	// Receiver start modes
	localparam logic [MODE_W-1:0] MODE_COLD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WARM   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HOT    = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STRONG_WIN = 3'd0,
		REG_WEAK_WIN   = 3'd1,
		REG_WARM_WIN   = 3'd2,
		REG_DOP_LIMIT  = 3'd3,
		REG_WEAK_PER   = 3'd4,
		REG_STRONG_OP  = 3'd5,
		REG_WEAK_OP    = 3'd6
	} ars_reg_t;

	// Register reset values
	localparam logic [WIN_W-1:0] RST_STRONG_WIN = 15'd10000;
	localparam logic [WIN_W-1:0] RST_WEAK_WIN   = 15'd10000;
	localparam logic [WIN_W-1:0] RST_WARM_WIN   = 15'd1000;
	localparam logic [WIN_W-1:0] RST_DOP_LIMIT  = 15'd20000;
	localparam logic [PER_W-1:0] RST_WEAK_PER   = 6'd4;
	localparam logic [OPC_W-1:0] RST_STRONG_OP  = OP_ALWAYS;
	localparam logic [OPC_W-1:0] RST_WEAK_OP    = OP_ALWAYS;

	// Channel table entry
	typedef struct packed {
		logic             empty;
		logic [SAT_W-1:0] sat;
	} chan_entry_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} ars_state_t;

endpackage

`default_nettype wire

// ----- rtl/ars_rem.sv -----
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle; flags a zero remainder.
module ars_rem import ars_pkg::*; #(
	parameter int NUM_W = 5
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] numer,
	input  wire logic [PER_W-1:0] denom,
	output logic                  busy,
	output logic                  rem_zero
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [NUM_W-1:0] num_q;
	logic [PER_W-1:0] den_q;
	logic [PER_W-1:0] rem_q;
	logic [PER_W:0]   trial;
	logic [PER_W:0]   rem_nx;

	// One shift-subtract step
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		if (trial >= {1'b0, den_q}) begin
			rem_nx = trial - {1'b0, den_q};
		end else begin
			rem_nx = trial;
		end
	end

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= rem_nx[PER_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign rem_zero = (rem_q == '0);

endmodule

`default_nettype wire

// ----- rtl/acquisition_request_scheduler.sv -----
`default_nettype none

// Acquisition request scheduler. A word with req_type 0 writes one entry of the
// channel table (ignored when chan_index >= NUM_CHANNELS) and gives no result.
// A word with req_type 1 is a slot: the table, kept in a one-port
// synchronous RAM with per-entry valid bits (all channels read empty after
// reset, no clearing pass), is read one channel per cycle while the
// weak-period remainder runs bit-serially alongside the scan, and no new word
// is taken until both have finished and the result is loaded. The result
// sits in an output register; a new word is taken while it waits, and a slot
// that finishes while it still waits holds until the old result is read.
module acquisition_request_scheduler import ars_pkg::*; #(
	parameter int NUM_SATS     = 32,
	parameter int NUM_CHANNELS = 12
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data,
	// input words
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         req_type,
	input  wire logic [CHAN_W-1:0]            chan_index,
	input  wire logic                         chan_empty,
	input  wire logic [SAT_W-1:0]             chan_sat,
	input  wire logic [MODE_W-1:0]            start_mode,
	input  wire logic                         almanac_valid,
	input  wire logic                         almanac_healthy,
	input  wire logic                         predicted_visible,
	input  wire logic signed [DOP_W-1:0]      predicted_doppler,
	input  wire logic signed [DOP_W-1:0]      predicted_rate,
	// result words
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              issue,
	output logic [SAT_W-1:0]                  sat,
	output logic                              acq_kind,
	output logic [MODE_W-1:0]                 acq_mode,
	output logic [CHAN_W-1:0]                 free_channel,
	output logic                              already_tracked,
	output logic signed [CENTRE_W-1:0]        centre_hz,
	output logic signed [BOUND_W-1:0]         low_hz,
	output logic signed [BOUND_W-1:0]         high_hz,
	output logic signed [DOP_W-1:0]           rate_term,
	output logic                              half_select,
	output logic [SAT_W-1:0]                  next_sat
);

	localparam int IDX_W  = $clog2(NUM_SATS);
	localparam int CH_A_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W  = $clog2(NUM_CHANNELS + 1);

	// Helpers
	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		logic [IDX_W:0] p;
		begin
			p = {1'b0, i} + 1'b1;
			return (p >= (IDX_W+1)'(NUM_SATS)) ? '0 : p[IDX_W-1:0];
		end
	endfunction

	function automatic logic [SAT_W-1:0] idx_to_sat(input logic [IDX_W-1:0] i);
		logic [IDX_W+SAT_W-1:0] w;
		begin
			w = {{SAT_W{1'b0}}, i};
			return w[SAT_W-1:0];
		end
	endfunction

	function automatic logic sat_match(input logic [SAT_W-1:0] s, input logic [IDX_W-1:0] i);
		return {{IDX_W{1'b0}}, s} == {{SAT_W{1'b0}}, i};
	endfunction

	function automatic logic [CHAN_W-1:0] ch_to_out(input logic [CH_A_W-1:0] c);
		logic [CH_A_W+CHAN_W-1:0] w;
		begin
			w = {{CHAN_W{1'b0}}, c};
			return w[CHAN_W-1:0];
		end
	endfunction

	// Configuration registers
	logic [WIN_W-1:0] strong_win_q, weak_win_q, warm_win_q, dop_limit_q;
	logic [PER_W-1:0] weak_per_q;
	logic [OPC_W-1:0] strong_op_q, weak_op_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strong_win_q <= RST_STRONG_WIN;
			weak_win_q   <= RST_WEAK_WIN;
			warm_win_q   <= RST_WARM_WIN;
			dop_limit_q  <= RST_DOP_LIMIT;
			weak_per_q   <= RST_WEAK_PER;
			strong_op_q  <= RST_STRONG_OP;
			weak_op_q    <= RST_WEAK_OP;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_STRONG_WIN: strong_win_q <= cfg_data[WIN_W-1:0];
				REG_WEAK_WIN:   weak_win_q   <= cfg_data[WIN_W-1:0];
				REG_WARM_WIN:   warm_win_q   <= cfg_data[WIN_W-1:0];
				REG_DOP_LIMIT:  dop_limit_q  <= cfg_data[WIN_W-1:0];
				REG_WEAK_PER:   weak_per_q   <= cfg_data[PER_W-1:0];
				REG_STRONG_OP:  strong_op_q  <= cfg_data[OPC_W-1:0];
				REG_WEAK_OP:    weak_op_q    <= cfg_data[OPC_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer
	ars_state_t       state_q, state_nx;
	logic [CNT_W-1:0] ad_q;
	logic             rd_en, rd_en_s1;
	logic             slot_acc, load, wr_en;
	logic             rem_busy, rem_zero;
	logic             out_valid_q;

	always_comb begin
		state_nx = state_q;
		in_ready = 1'b0;
		slot_acc = 1'b0;
		rd_en    = 1'b0;
		load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && req_type == REQ_SLOT) begin
					slot_acc = 1'b1;
					state_nx = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = (ad_q < CNT_W'(NUM_CHANNELS));
				if (!rd_en && !rd_en_s1 && !rem_busy) begin
					state_nx = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					load     = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Rotation state
	logic [IDX_W-1:0] sidx_q, widx_q, cur_idx, sidx_nx, widx_nx, widx_new, sidx_new;
	logic             phase_q, eo_q, phase_new;
	logic [PER_W-1:0] period;

	assign cur_idx = phase_q ? widx_q : sidx_q;
	assign sidx_nx = next_idx(sidx_q);
	assign widx_nx = eo_q ? next_idx(widx_q) : widx_q;
	assign period  = (weak_per_q == '0) ? PER_W'(1) : weak_per_q;

	// Weak-period remainder of the advanced weak index
	ars_rem #(
		.NUM_W (IDX_W)
	) u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (slot_acc),
		.numer    (widx_nx),
		.denom    (period),
		.busy     (rem_busy),
		.rem_zero (rem_zero)
	);

	always_comb begin
		sidx_new  = sidx_q;
		widx_new  = widx_q;
		phase_new = phase_q;
		if (!phase_q) begin
			sidx_new  = sidx_nx;
			phase_new = (sidx_nx == '0);
		end else begin
			widx_new  = widx_nx;
			phase_new = !rem_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sidx_q  <= '0;
			widx_q  <= '0;
			phase_q <= 1'b0;
			eo_q    <= 1'b0;
		end else if (load) begin
			sidx_q  <= sidx_new;
			widx_q  <= widx_new;
			phase_q <= phase_new;
			if (phase_q) begin
				eo_q <= !eo_q;
			end
		end
	end

	// Channel table RAM
	chan_entry_t             mem [NUM_CHANNELS];
	chan_entry_t             rd_s1;
	logic [NUM_CHANNELS-1:0] vld_q;
	logic                    vld_s1;
	logic [CH_A_W-1:0]       rd_addr, wr_addr, idx_s1;

	assign wr_addr = chan_index[CH_A_W-1:0];
	assign rd_addr = ad_q[CH_A_W-1:0];
	assign wr_en   = in_valid && in_ready && req_type == REQ_UPDATE &&
	                 ({1'b0, chan_index} < (CHAN_W+1)'(NUM_CHANNELS));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= '{empty: chan_empty, sat: chan_sat};
		end
		if (rd_en) begin
			rd_s1  <= mem[rd_addr];
			vld_s1 <= vld_q[rd_addr];
			idx_s1 <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Scan: highest empty channel and tracked check
	logic              tracked_q, have_free_q;
	logic [CH_A_W-1:0] free_q;
	logic              ent_empty;
	logic [SAT_W-1:0]  ent_sat;

	assign ent_empty = !vld_s1 || rd_s1.empty;
	assign ent_sat   = vld_s1 ? rd_s1.sat : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ad_q        <= '0;
			rd_en_s1    <= 1'b0;
			tracked_q   <= 1'b0;
			have_free_q <= 1'b0;
			free_q      <= '0;
		end else begin
			rd_en_s1 <= rd_en;
			if (slot_acc) begin
				ad_q        <= '0;
				tracked_q   <= 1'b0;
				have_free_q <= 1'b0;
				free_q      <= '0;
			end else begin
				if (rd_en) begin
					ad_q <= ad_q + 1'b1;
				end
				if (rd_en_s1) begin
					if (ent_empty) begin
						free_q      <= idx_s1;
						have_free_q <= 1'b1;
					end else if (sat_match(ent_sat, cur_idx)) begin
						tracked_q <= 1'b1;
					end
				end
			end
		end
	end

	// Captured slot fields
	logic [MODE_W-1:0]        mode_q;
	logic                     alm_vld_q, alm_ok_q, vis_q;
	logic signed [DOP_W-1:0]  dop_q, rate_in_q;

	always_ff @(posedge clk) begin
		if (slot_acc) begin
			mode_q    <= (start_mode == MODE_UNUSED) ? MODE_HOT : start_mode;
			alm_vld_q <= almanac_valid;
			alm_ok_q  <= almanac_healthy;
			vis_q     <= predicted_visible;
			dop_q     <= predicted_doppler;
			rate_in_q <= predicted_rate;
		end
	end

	// Centre clamp, registered during the scan
	logic signed [DOP_W-1:0]    lim_pos, lim_neg, centre_c;
	logic                       clamp_c;
	logic signed [CENTRE_W-1:0] centre_q;
	logic signed [DOP_W-1:0]    rate_q;

	always_comb begin
		lim_pos  = signed'({{(DOP_W-WIN_W){1'b0}}, dop_limit_q});
		lim_neg  = -lim_pos;
		clamp_c  = 1'b1;
		if (dop_q < lim_neg) begin
			centre_c = lim_neg;
		end else if (dop_q > lim_pos) begin
			centre_c = lim_pos;
		end else begin
			centre_c = dop_q;
			clamp_c  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN) begin
			centre_q <= centre_c[CENTRE_W-1:0];
			rate_q   <= clamp_c ? '0 : rate_in_q;
		end
	end

	// Decision and window
	logic [OPC_W-1:0]          op;
	logic [WIN_W-1:0]          mwin;
	logic                      use_pred, doacq;
	logic signed [BOUND_W-1:0] centre_ext, warm_ext, mwin_ext;
	logic signed [BOUND_W-1:0] low_c, high_c;
	logic signed [CENTRE_W-1:0] centre_o;
	logic signed [DOP_W-1:0]   rate_o;
	logic [MODE_W-1:0]         tag;

	always_comb begin
		op         = phase_q ? weak_op_q : strong_op_q;
		mwin       = phase_q ? weak_win_q : strong_win_q;
		use_pred   = alm_vld_q && mode_q != MODE_COLD;
		doacq      = !(op == OP_OFF) && !(op == OP_NOT_COLD && mode_q == MODE_COLD);
		centre_ext = {centre_q[CENTRE_W-1], centre_q};
		warm_ext   = signed'({2'b00, warm_win_q});
		mwin_ext   = signed'({2'b00, mwin});
		if (use_pred) begin
			centre_o = centre_q;
			rate_o   = rate_q;
			low_c    = centre_ext - warm_ext;
			high_c   = centre_ext + warm_ext;
			tag      = mode_q;
			doacq    = doacq && alm_ok_q && vis_q;
		end else begin
			centre_o = '0;
			rate_o   = '0;
			low_c    = -mwin_ext;
			high_c   = mwin_ext;
			tag      = MODE_COLD;
		end
	end

	// Output register
	logic                       issue_q, kind_q, tracked_o_q, half_q;
	logic [SAT_W-1:0]           sat_q, next_sat_q;
	logic [MODE_W-1:0]          acq_mode_q;
	logic [CHAN_W-1:0]          free_o_q;
	logic signed [CENTRE_W-1:0] centre_o_q;
	logic signed [BOUND_W-1:0]  low_q, high_q;
	logic signed [DOP_W-1:0]    rate_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			issue_q     <= doacq && !tracked_q && have_free_q;
			sat_q       <= idx_to_sat(cur_idx);
			kind_q      <= phase_q;
			acq_mode_q  <= tag;
			free_o_q    <= ch_to_out(free_q);
			tracked_o_q <= tracked_q;
			centre_o_q  <= centre_o;
			low_q       <= low_c;
			high_q      <= high_c;
			rate_o_q    <= rate_o;
			half_q      <= eo_q;
			next_sat_q  <= idx_to_sat(phase_new ? widx_new : sidx_new);
		end
	end

	assign out_valid       = out_valid_q;
	assign issue           = issue_q;
	assign sat             = sat_q;
	assign acq_kind        = kind_q;
	assign acq_mode        = acq_mode_q;
	assign free_channel    = free_o_q;
	assign already_tracked = tracked_o_q;
	assign centre_hz       = centre_o_q;
	assign low_hz          = low_q;
	assign high_hz         = high_q;
	assign rate_term       = rate_o_q;
	assign half_select     = half_q;
	assign next_sat        = next_sat_q;

	// Checks
	a_no_issue_when_tracked: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(issue && already_tracked))
		else $error("request issued for a tracked satellite");

	a_rem_started: assert property (@(posedge clk) disable iff (!arst_n)
		slot_acc |=> rem_busy)
		else $error("remainder unit not started with slot");

	a_load_after_rem: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !rem_busy)
		else $error("result loaded before remainder finished");

	a_scan_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |-> (ad_q == CNT_W'(NUM_CHANNELS) && !rd_en_s1))
		else $error("finish reached before channel scan completed");

endmodule

`default_nettype wire

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

import ars_pkg::*;

// One input word as the sender offers it
typedef struct packed {
	logic                    req_type;
	logic [CHAN_W-1:0]       chan_index;
	logic                    chan_empty;
	logic [SAT_W-1:0]        chan_sat;
	logic [MODE_W-1:0]       start_mode;
	logic                    almanac_valid;
	logic                    almanac_healthy;
	logic                    predicted_visible;
	logic signed [DOP_W-1:0] predicted_doppler;
	logic signed [DOP_W-1:0] predicted_rate;
} sched_word_t;

// One slot decision as the block reports it
typedef struct packed {
	logic                       issue;
	logic [SAT_W-1:0]           sat;
	logic                       acq_kind;
	logic [MODE_W-1:0]          acq_mode;
	logic [CHAN_W-1:0]          free_channel;
	logic                       already_tracked;
	logic signed [CENTRE_W-1:0] centre_hz;
	logic signed [BOUND_W-1:0]  low_hz;
	logic signed [BOUND_W-1:0]  high_hz;
	logic signed [DOP_W-1:0]    rate_term;
	logic                       half_select;
	logic [SAT_W-1:0]           next_sat;
} sched_result_t;

// Tracks the scheduler's rotation and channel table, and holds the slot
// decisions still owed by the block
class slot_outcomes #(int SATS = 32, int CHANNELS = 12);
	logic [WIN_W-1:0] strong_win, weak_win, warm_win, doppler_lim;
	logic [PER_W-1:0] weak_per;
	logic [OPC_W-1:0] strong_op, weak_op;
	int unsigned strong_idx, weak_idx;
	bit weak_ph, even_odd;
	bit empty_tab [CHANNELS];
	logic [SAT_W-1:0] sat_tab [CHANNELS];
	sched_result_t due [$];
	int mismatches;

	function new();
		strong_win = RST_STRONG_WIN;
		weak_win = RST_WEAK_WIN;
		warm_win = RST_WARM_WIN;
		doppler_lim = RST_DOP_LIMIT;
		weak_per = RST_WEAK_PER;
		strong_op = RST_STRONG_OP;
		weak_op = RST_WEAK_OP;
		strong_idx = 0;
		weak_idx = 0;
		weak_ph = 1'b0;
		even_odd = 1'b0;
		foreach (empty_tab[k]) begin
			empty_tab[k] = 1'b1;
			sat_tab[k] = '0;
		end
		mismatches = 0;
	endfunction

	function int pending();
		return due.size();
	endfunction

	function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_STRONG_WIN: strong_win = data[WIN_W-1:0];
			REG_WEAK_WIN:   weak_win = data[WIN_W-1:0];
			REG_WARM_WIN:   warm_win = data[WIN_W-1:0];
			REG_DOP_LIMIT:  doppler_lim = data[WIN_W-1:0];
			REG_WEAK_PER:   weak_per = data[PER_W-1:0];
			REG_STRONG_OP:  strong_op = data[OPC_W-1:0];
			REG_WEAK_OP:    weak_op = data[OPC_W-1:0];
			default: ;
		endcase
	endfunction

	function int unsigned step_sat(int unsigned i);
		return (i + 1 >= SATS) ? 0 : i + 1;
	endfunction

	// Accepted word: table write, or a slot decision plus rotation step
	function void take_word(sched_word_t w);
		logic [MODE_W-1:0] mode, tag;
		logic [OPC_W-1:0] op;
		int unsigned cur, per;
		int free_ch;
		bit have_free, tracked, go;
		longint centre, rate, low, high, win, lim;
		sched_result_t r;

		if (w.req_type == REQ_UPDATE) begin
			if (w.chan_index < CHANNELS) begin
				empty_tab[w.chan_index] = w.chan_empty;
				sat_tab[w.chan_index] = w.chan_sat;
			end
			return;
		end

		mode = (w.start_mode == MODE_UNUSED) ? MODE_HOT : w.start_mode;
		cur = weak_ph ? weak_idx : strong_idx;

		// highest empty channel wins; only occupied channels count as tracking
		free_ch = 0;
		have_free = 1'b0;
		tracked = 1'b0;
		for (int k = 0; k < CHANNELS; k++) begin
			if (empty_tab[k]) begin
				free_ch = k;
				have_free = 1'b1;
			end else if (sat_tab[k] == SAT_W'(cur)) begin
				tracked = 1'b1;
			end
		end

		op = weak_ph ? weak_op : strong_op;
		go = !(op == OP_OFF) && !(op == OP_NOT_COLD && mode == MODE_COLD);

		// cold window unless a usable prediction exists
		win = weak_ph ? weak_win : strong_win;
		centre = 0;
		rate = 0;
		low = -win;
		high = win;
		tag = MODE_COLD;
		if (w.almanac_valid && mode != MODE_COLD) begin
			lim = doppler_lim;
			centre = longint'($signed(w.predicted_doppler));
			rate = longint'($signed(w.predicted_rate));
			if (centre < -lim) begin
				centre = -lim;
				rate = 0;
			end
			if (centre > lim) begin
				centre = lim;
				rate = 0;
			end
			low = centre - longint'(warm_win);
			high = centre + longint'(warm_win);
			tag = mode;
			if (!w.almanac_healthy || !w.predicted_visible)
				go = 1'b0;
		end

		r.issue = go && !tracked && have_free;
		r.sat = SAT_W'(cur);
		r.acq_kind = weak_ph;
		r.acq_mode = tag;
		r.free_channel = have_free ? CHAN_W'(free_ch) : '0;
		r.already_tracked = tracked;
		r.centre_hz = centre[CENTRE_W-1:0];
		r.low_hz = low[BOUND_W-1:0];
		r.high_hz = high[BOUND_W-1:0];
		r.rate_term = rate[DOP_W-1:0];
		r.half_select = even_odd;

		// strong pass runs once round; weak pass visits each sat twice
		if (!weak_ph) begin
			strong_idx = step_sat(strong_idx);
			if (strong_idx == 0)
				weak_ph = 1'b1;
		end else begin
			if (!even_odd) begin
				even_odd = 1'b1;
			end else begin
				even_odd = 1'b0;
				weak_idx = step_sat(weak_idx);
			end
			per = (weak_per == 0) ? 1 : weak_per;
			if (weak_idx % per == 0)
				weak_ph = 1'b0;
		end
		r.next_sat = SAT_W'(weak_ph ? weak_idx : strong_idx);
		due.push_back(r);
	endfunction

	function void report(string field, logic [DOP_W-1:0] e, logic [DOP_W-1:0] a);
		$display("%0t: %s expected %0h, got %0h", $time, field, e, a);
		mismatches++;
	endfunction

	// Accepted result word against the oldest owed decision
	function void check_slot(sched_result_t a);
		sched_result_t e;

		if (due.size() == 0) begin
			$display("%0t: result word with nothing owed, sat %0d", $time, a.sat);
			mismatches++;
			return;
		end
		e = due.pop_front();
		if (e.issue !== a.issue) report("issue", e.issue, a.issue);
		if (e.sat !== a.sat) report("sat", e.sat, a.sat);
		if (e.acq_kind !== a.acq_kind) report("acq_kind", e.acq_kind, a.acq_kind);
		if (e.acq_mode !== a.acq_mode) report("acq_mode", e.acq_mode, a.acq_mode);
		if (e.free_channel !== a.free_channel)
			report("free_channel", e.free_channel, a.free_channel);
		if (e.already_tracked !== a.already_tracked)
			report("already_tracked", e.already_tracked, a.already_tracked);
		if (e.centre_hz !== a.centre_hz) report("centre_hz", e.centre_hz, a.centre_hz);
		if (e.low_hz !== a.low_hz) report("low_hz", e.low_hz, a.low_hz);
		if (e.high_hz !== a.high_hz) report("high_hz", e.high_hz, a.high_hz);
		if (e.rate_term !== a.rate_term) report("rate_term", e.rate_term, a.rate_term);
		if (e.half_select !== a.half_select)
			report("half_select", e.half_select, a.half_select);
		if (e.next_sat !== a.next_sat) report("next_sat", e.next_sat, a.next_sat);
	endfunction
endclass

module tb;
	localparam int NUM_SATS = 32;
	localparam int NUM_CHANNELS = 12;
	localparam int PHASES = 8;
	localparam int WORDS_PER_PHASE = 200;
	localparam int HOLD_CYCLES = 500;
	localparam int SETTLE_CYCLES = 24;
	localparam int STALL_LIMIT = 4000;
	localparam logic [OPC_W-1:0] OP_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic req_type;
	logic [CHAN_W-1:0] chan_index;
	logic chan_empty;
	logic [SAT_W-1:0] chan_sat;
	logic [MODE_W-1:0] start_mode;
	logic almanac_valid;
	logic almanac_healthy;
	logic predicted_visible;
	logic signed [DOP_W-1:0] predicted_doppler;
	logic signed [DOP_W-1:0] predicted_rate;
	logic out_valid;
	logic out_ready;
	logic issue;
	logic [SAT_W-1:0] sat;
	logic acq_kind;
	logic [MODE_W-1:0] acq_mode;
	logic [CHAN_W-1:0] free_channel;
	logic already_tracked;
	logic signed [CENTRE_W-1:0] centre_hz;
	logic signed [BOUND_W-1:0] low_hz;
	logic signed [BOUND_W-1:0] high_hz;
	logic signed [DOP_W-1:0] rate_term;
	logic half_select;
	logic [SAT_W-1:0] next_sat;

	slot_outcomes #(NUM_SATS, NUM_CHANNELS) board;
	sched_result_t seen;
	int send_idle_pct = 19;
	int recv_idle_pct = 85;
	bit hold_off_req = 1'b0;
	int quiet = 0;

	acquisition_request_scheduler #(
		.NUM_SATS(NUM_SATS),
		.NUM_CHANNELS(NUM_CHANNELS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.chan_index(chan_index),
		.chan_empty(chan_empty),
		.chan_sat(chan_sat),
		.start_mode(start_mode),
		.almanac_valid(almanac_valid),
		.almanac_healthy(almanac_healthy),
		.predicted_visible(predicted_visible),
		.predicted_doppler(predicted_doppler),
		.predicted_rate(predicted_rate),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.issue(issue),
		.sat(sat),
		.acq_kind(acq_kind),
		.acq_mode(acq_mode),
		.free_channel(free_channel),
		.already_tracked(already_tracked),
		.centre_hz(centre_hz),
		.low_hz(low_hz),
		.high_hz(high_hz),
		.rate_term(rate_term),
		.half_select(half_select),
		.next_sat(next_sat)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	assign seen = {issue, sat, acq_kind, acq_mode, free_channel, already_tracked,
		centre_hz, low_hz, high_hz, rate_term, half_select, next_sat};

	// result words are checked at the edge that takes them
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_slot(seen);
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
			end
			out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// give up when no channel moves a word for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, quiet);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// enters and leaves at a falling edge
	task automatic send_word(input sched_word_t w);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		req_type = w.req_type;
		chan_index = w.chan_index;
		chan_empty = w.chan_empty;
		chan_sat = w.chan_sat;
		start_mode = w.start_mode;
		almanac_valid = w.almanac_valid;
		almanac_healthy = w.almanac_healthy;
		predicted_visible = w.predicted_visible;
		predicted_doppler = w.predicted_doppler;
		predicted_rate = w.predicted_rate;
		in_valid = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.take_word(w);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_index = idx;
		cfg_data = data;
		cfg_valid = 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.set_reg(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// stop offering, wait for every owed slot, then let a table write finish
	task automatic drain();
		in_valid = 1'b0;
		while (board.pending() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic sched_word_t update_of(input logic [CHAN_W-1:0] idx,
			input logic empty, input logic [SAT_W-1:0] sat_no);
		sched_word_t w;
		w = {$urandom, $urandom, 16'($urandom)};
		w.req_type = REQ_UPDATE;
		w.chan_index = idx;
		w.chan_empty = empty;
		w.chan_sat = sat_no;
		return w;
	endfunction

	function automatic sched_word_t slot_of(input logic [MODE_W-1:0] mode,
			input logic av, input logic ah, input logic pv,
			input logic signed [DOP_W-1:0] dop, input logic signed [DOP_W-1:0] rate);
		sched_word_t w;
		w = {$urandom, $urandom, 16'($urandom)};
		w.req_type = REQ_SLOT;
		w.start_mode = mode;
		w.almanac_valid = av;
		w.almanac_healthy = ah;
		w.predicted_visible = pv;
		w.predicted_doppler = dop;
		w.predicted_rate = rate;
		return w;
	endfunction

	function automatic sched_word_t random_word();
		sched_word_t w;
		int d;
		w = {$urandom, $urandom, 16'($urandom)};
		if ($urandom_range(0, 9) < 7) begin
			w.req_type = REQ_SLOT;
			w.almanac_valid = ($urandom_range(0, 3) != 0);
			w.almanac_healthy = ($urandom_range(0, 3) != 0);
			w.predicted_visible = ($urandom_range(0, 3) != 0);
			// Doppler: full range, receiver range, right at the clamp, near zero
			case ($urandom_range(0, 3))
				0: d = $urandom;
				1: d = int'($urandom_range(0, 80000)) - 40000;
				2: begin
					d = int'(board.doppler_lim) + int'($urandom_range(0, 2)) - 1;
					if ($urandom_range(0, 1))
						d = -d;
				end
				default: d = int'($urandom_range(0, 4000)) - 2000;
			endcase
			w.predicted_doppler = d;
			if ($urandom_range(0, 1))
				w.predicted_rate = int'($urandom_range(0, 200000)) - 100000;
		end else begin
			w.req_type = REQ_UPDATE;
			if ($urandom_range(0, 99) < 90)
				w.chan_index = CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
			w.chan_empty = ($urandom_range(0, 9) < 4);
		end
		return w;
	endfunction

	// one register setting per phase; the first ones hit the extremes
	task automatic program_phase(input int ph);
		logic [WIN_W-1:0] sw, ww, warm, lim;
		logic [PER_W-1:0] per;
		logic [OPC_W-1:0] sop, wop;
		logic [CFG_DATA_W-PER_W-1:0] junk_p;
		logic [CFG_DATA_W-OPC_W-1:0] junk_s, junk_w;

		sw = WIN_W'($urandom_range(0, 32767));
		ww = WIN_W'($urandom_range(0, 32767));
		warm = WIN_W'($urandom_range(0, 5000));
		lim = WIN_W'($urandom_range(0, 32767));
		per = PER_W'($urandom_range(1, 32));
		sop = OPC_W'($urandom_range(0, 3));
		wop = OPC_W'($urandom_range(0, 3));
		junk_p = (CFG_DATA_W-PER_W)'($urandom);
		junk_s = (CFG_DATA_W-OPC_W)'($urandom);
		junk_w = (CFG_DATA_W-OPC_W)'($urandom);
		case (ph)
			1: begin
				sw = '1;
				ww = '1;
				warm = '1;
				lim = '1;
				per = 6'd1;
				sop = OP_ALWAYS;
				wop = OP_ALWAYS;
			end
			2: begin
				sw = '0;
				ww = '0;
				warm = '0;
				lim = '0;
				per = '0;
				sop = OP_NOT_COLD;
				wop = OP_NOT_COLD;
			end
			3: begin
				per = 6'd32;
				sop = OP_SPARE;
				wop = OP_OFF;
			end
			4: begin
				per = '1;
				sop = OP_OFF;
				wop = OP_SPARE;
			end
			default: ;
		endcase
		write_reg(REG_STRONG_WIN, sw);
		write_reg(REG_WEAK_WIN, ww);
		write_reg(REG_WARM_WIN, warm);
		write_reg(REG_DOP_LIMIT, lim);
		write_reg(REG_WEAK_PER, {junk_p, per});
		write_reg(REG_STRONG_OP, {junk_s, sop});
		write_reg(REG_WEAK_OP, {junk_w, wop});
		if (ph == 1)
			write_reg(REG_UNMAPPED, '1);
	endtask

	initial begin
		board = new();
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		req_type = REQ_UPDATE;
		chan_index = '0;
		chan_empty = 1'b0;
		chan_sat = '0;
		start_mode = MODE_COLD;
		almanac_valid = 1'b0;
		almanac_healthy = 1'b0;
		predicted_visible = 1'b0;
		predicted_doppler = '0;
		predicted_rate = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed words at reset settings
		send_word(slot_of(MODE_COLD, 1'b0, 1'b0, 1'b0, '0, '0));
		send_word(update_of(4'd11, 1'b0, 5'd1));
		// sat 1 now tracked; centre clamped high
		send_word(slot_of(MODE_WARM, 1'b1, 1'b1, 1'b1, 32'sh7FFFFFFF, -32'sd1));
		send_word(slot_of(MODE_HOT, 1'b1, 1'b1, 1'b1, 32'sh80000000, 32'sh7FFFFFFF));
		send_word(slot_of(MODE_UNUSED, 1'b1, 1'b0, 1'b1, 32'sd123, 32'sh80000000));
		send_word(slot_of(MODE_WARM, 1'b1, 1'b1, 1'b0, -32'sd500, 32'sd77));
		send_word(slot_of(MODE_HOT, 1'b0, 1'b1, 1'b1, 32'sd5000, 32'sd9));
		// out-of-range channel writes are dropped
		send_word(update_of(4'd15, 1'b0, 5'd31));
		send_word(update_of(4'd12, 1'b0, 5'd31));
		// fill the whole table: no free channel
		for (int i = 0; i < NUM_CHANNELS - 1; i++)
			send_word(update_of(CHAN_W'(i), 1'b0, SAT_W'(20 + i)));
		send_word(slot_of(MODE_HOT, 1'b1, 1'b1, 1'b1, 32'sd100, 32'sd5));
		send_word(update_of(4'd11, 1'b1, 5'd31));
		// centre exactly on the limit stays unclamped
		send_word(slot_of(MODE_WARM, 1'b1, 1'b1, 1'b1, 32'sd20000, -32'sd4096));

		for (int ph = 1; ph <= PHASES; ph++) begin
			drain();
			program_phase(ph);
			if (ph <= 3) begin
				send_idle_pct = 19;
				recv_idle_pct = 85;
			end else if (ph <= 6) begin
				send_idle_pct = 85;
				recv_idle_pct = 19;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// back the block up into its input once
			if (ph == 7)
				hold_off_req = 1'b1;
			repeat (WORDS_PER_PHASE) send_word(random_word());
		end
		drain();

		if (board.mismatches == 0 && board.pending() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- acquisition_request_scheduler.f -----
rtl/ars_pkg.sv
rtl/ars_rem.sv
rtl/acquisition_request_scheduler.sv
bench/tb.sv
